// ===== hdl/brb_pkg.sv =====
// ============================================================================
// brb_pkg
// Shared widths, request codes and index arithmetic for the byte ring buffer.
// ============================================================================
`default_nettype none

package brb_pkg;

   // Physical slots in the ring memory.
   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);

   // Fixed field widths.
   localparam int TYPE_W = 2;
   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;
   localparam int SIZE_W = 7;

   localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(DEPTH);

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_PUSH    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_PEEK    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DISCARD = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_POP     = 2'd3;

   // Index plus offset, wrapped at the ring size. The caller keeps
   // idx + delta below twice the size, so one subtraction is enough.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0]  idx,
                                                 input logic [SIZE_W-1:0] delta,
                                                 input logic [SIZE_W-1:0] size);
      logic [SIZE_W:0] sum;
      sum = {2'b00, idx} + {1'b0, delta};
      if (sum >= {1'b0, size}) begin
         sum = sum - {1'b0, size};
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/brb_req_if.sv =====
// ============================================================================
// brb_req_if
// Request channel of the byte ring buffer: valid/ready and one request.
// ============================================================================
`default_nettype none

interface brb_req_if import brb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [LEN_W-1:0]  req_length;
   logic [BYTE_W-1:0] push_byte;

   modport source (output valid, req_type, req_length, push_byte, input ready);
   modport sink   (input valid, req_type, req_length, push_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/brb_rsp_if.sv =====
// ============================================================================
// brb_rsp_if
// Response channel of the byte ring buffer: valid/ready and one result.
// ============================================================================
`default_nettype none

interface brb_rsp_if import brb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              ok;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_valid;
   logic [LEN_W-1:0]  byte_count;
   logic              run_last;
   logic [LEN_W-1:0]  used_count;
   logic [LEN_W-1:0]  free_count;

   modport source (output valid, ok, out_byte, byte_valid, byte_count, run_last,
                   used_count, free_count, input ready);
   modport sink   (input valid, ok, out_byte, byte_valid, byte_count, run_last,
                   used_count, free_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/byte_ring_buffer_unit.sv =====
// ============================================================================
// byte_ring_buffer_unit
// Circular byte FIFO with one slot kept empty, run-based push and read runs.
// ============================================================================
//
//   Channel   Direction  Handshake           Carries
//   req_if    in         valid/ready         req_type, req_length, push_byte
//   rsp_if    out        valid/ready         ok, out_byte, byte_valid,
//                                            byte_count, run_last, used_count,
//                                            free_count
//   csr_*     in         write enable only   ring_size (7 bits)
//
// Each push byte is written to the ring memory in the cycle that accepts it;
// only the last byte of a push run produces a result. A peek or pop of n
// bytes occupies the block from the accepting cycle, through a read on the
// single registered read port of the ring memory, then returns one byte per
// cycle while the consumer takes them; no new request is taken until the last
// byte of the run has moved into the output register.
// The output register frees in the cycle the consumer takes its result, so a
// stalled consumer holds the block but loses nothing.
// Reset is synchronous and clears the indices, the push state and the size
// (back to 64); the memory itself is not cleared, as only written entries
// are ever read.
// ============================================================================
`default_nettype none

module byte_ring_buffer_unit import brb_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   brb_req_if.sink             req_if,
   brb_rsp_if.source           rsp_if,
   input  wire                 csr_wr_en,
   input  wire  [SIZE_W-1:0]   csr_wr_data
);

   // Control states: idle takes requests, read streams a peek or pop run.
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0]  push_rcv_ff, push_rcv_in;
   logic              push_ok_ff, push_ok_in;
   logic              st_ff, st_in;

   // Read run bookkeeping.
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [LEN_W-1:0]  iss_cnt_ff, iss_cnt_in;
   logic [LEN_W-1:0]  run_n_ff, run_n_in;
   logic [LEN_W-1:0]  after_ff, after_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_bvalid_ff, rsp_bvalid_in;
   logic [LEN_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]  rsp_used_ff, rsp_used_in;
   logic [LEN_W-1:0]  rsp_free_ff, rsp_free_in;

   // Ring memory with a registered read port.
   logic [BYTE_W-1:0] ring_mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic              mem_re;

   // ------------------------------------------------------------------------
   // Occupancy of the ring, derived from the two indices.
   // ------------------------------------------------------------------------
   logic [SIZE_W-1:0] used_now;
   logic [SIZE_W-1:0] free_now;

   always_comb begin
      if (wr_idx_ff >= rd_idx_ff) begin
         used_now = {1'b0, wr_idx_ff} - {1'b0, rd_idx_ff};
      end else begin
         used_now = size_ff - ({1'b0, rd_idx_ff} - {1'b0, wr_idx_ff});
      end
      free_now = size_ff - SIZE_W'(1) - used_now;
   end

   // The output register can take a new result when empty or being drained.
   logic out_free;
   logic req_fire;
   logic move;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_fire = req_if.valid && req_if.ready;

   // A fetched byte moves to the output register once that register frees.
   assign move   = pend_ff && out_free;
   // A new memory read is issued while the run has bytes left and the read
   // data register is empty or being emptied in this cycle.
   assign mem_re = (st_ff == ST_READ) && (iss_cnt_ff != run_n_ff) && (!pend_ff || move);

   assign req_if.ready = (st_ff == ST_IDLE) && out_free;

   // ------------------------------------------------------------------------
   // Request handling
   // ------------------------------------------------------------------------
   logic [SIZE_W-1:0] len_w;
   logic              acc;
   logic [SIZE_W-1:0] rcv_next;
   logic [SIZE_W-1:0] run_len;

   always_comb begin
      size_in       = size_ff;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      push_rcv_in   = push_rcv_ff;
      push_ok_in    = push_ok_ff;
      st_in         = st_ff;
      addr_in       = addr_ff;
      iss_cnt_in    = iss_cnt_ff;
      run_n_in      = run_n_ff;
      after_in      = after_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;

      mem_we    = 1'b0;
      mem_waddr = wrap_add(wr_idx_ff, {1'b0, push_rcv_ff}, size_ff);

      len_w    = {1'b0, req_if.req_length};
      acc      = 1'b0;
      rcv_next = {1'b0, push_rcv_ff} + SIZE_W'(1);
      run_len  = (len_w < used_now) ? len_w : used_now;

      if (req_fire) begin
         // Any single-result request fills in this default failing result.
         rsp_ok_in     = 1'b0;
         rsp_byte_in   = '0;
         rsp_bvalid_in = 1'b0;
         rsp_cnt_in    = '0;
         rsp_last_in   = 1'b1;
         rsp_used_in   = used_now[LEN_W-1:0];
         rsp_free_in   = free_now[LEN_W-1:0];

         if (req_if.req_type == REQ_PUSH) begin
            if (push_rcv_ff == '0 && len_w == '0) begin
               // Empty push: fail at once, nothing is in progress.
               rsp_valid_in = 1'b1;
            end else begin
               // Space is decided on the first byte; a run that grows past
               // the free space later on fails as a whole.
               acc = (push_rcv_ff == '0) ? (len_w <= free_now) : push_ok_ff;
               if (acc && {1'b0, push_rcv_ff} >= free_now) begin
                  acc = 1'b0;
               end
               mem_we = acc;
               if (rcv_next >= len_w) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = acc;
                  push_rcv_in  = '0;
                  push_ok_in   = 1'b0;
                  if (acc) begin
                     wr_idx_in   = wrap_add(wr_idx_ff, rcv_next, size_ff);
                     rsp_cnt_in  = rcv_next[LEN_W-1:0];
                     rsp_used_in = LEN_W'(used_now + rcv_next);
                     rsp_free_in = LEN_W'(free_now - rcv_next);
                  end
               end else begin
                  push_rcv_in = rcv_next[LEN_W-1:0];
                  push_ok_in  = acc;
               end
            end
         end else begin
            // Any other request drops an unfinished push.
            push_rcv_in = '0;
            push_ok_in  = 1'b0;
            if (req_if.req_type == REQ_DISCARD) begin
               rsp_valid_in = 1'b1;
               if (len_w != '0 && len_w <= used_now) begin
                  rd_idx_in   = wrap_add(rd_idx_ff, len_w, size_ff);
                  rsp_ok_in   = 1'b1;
                  rsp_cnt_in  = req_if.req_length;
                  rsp_used_in = LEN_W'(used_now - len_w);
                  rsp_free_in = LEN_W'(free_now + len_w);
               end
            end else if (len_w == '0 || used_now == '0) begin
               // Peek or pop with nothing to return.
               rsp_valid_in = 1'b1;
            end else begin
               // Start a read run; a pop takes its bytes out right away, as
               // nothing else touches the ring until the run is over.
               st_in      = ST_READ;
               addr_in    = rd_idx_ff;
               iss_cnt_in = '0;
               run_n_in   = run_len[LEN_W-1:0];
               if (req_if.req_type == REQ_POP) begin
                  rd_idx_in = wrap_add(rd_idx_ff, run_len, size_ff);
                  after_in  = LEN_W'(used_now - run_len);
               end else begin
                  after_in  = used_now[LEN_W-1:0];
               end
            end
         end
      end

      // Read run: issue, then move fetched bytes to the output register.
      if (mem_re) begin
         addr_in      = wrap_add(addr_ff, SIZE_W'(1), size_ff);
         iss_cnt_in   = iss_cnt_ff + LEN_W'(1);
         pend_last_in = (iss_cnt_ff == run_n_ff - LEN_W'(1));
      end
      if (move) begin
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = 1'b1;
         rsp_byte_in   = rdata_ff;
         rsp_bvalid_in = 1'b1;
         rsp_cnt_in    = run_n_ff;
         rsp_last_in   = pend_last_ff;
         rsp_used_in   = after_ff;
         rsp_free_in   = LEN_W'(size_ff - SIZE_W'(1) - {1'b0, after_ff});
         if (pend_last_ff) begin
            st_in = ST_IDLE;
         end
      end
      pend_in = mem_re || (pend_ff && !move);

      // Size write empties the ring; user must send it only when idle (unchecked).
      if (csr_wr_en) begin
         if (csr_wr_data < SIZE_MIN) begin
            size_in = SIZE_MIN;
         end else if (csr_wr_data > SIZE_MAX) begin
            size_in = SIZE_MAX;
         end else begin
            size_in = csr_wr_data;
         end
         wr_idx_in   = '0;
         rd_idx_in   = '0;
         push_rcv_in = '0;
         push_ok_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_MAX;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         push_rcv_ff  <= '0;
         push_ok_ff   <= 1'b0;
         st_ff        <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         push_rcv_ff  <= push_rcv_in;
         push_ok_ff   <= push_ok_in;
         st_ff        <= st_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and run bookkeeping need no reset.
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      iss_cnt_ff    <= iss_cnt_in;
      run_n_ff      <= run_n_in;
      after_ff      <= after_in;
      pend_last_ff  <= pend_last_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Ring memory: one write port for push bytes, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= req_if.push_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= ring_mem[addr_ff];
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ok         = rsp_ok_ff;
   assign rsp_if.out_byte   = rsp_byte_ff;
   assign rsp_if.byte_valid = rsp_bvalid_ff;
   assign rsp_if.byte_count = rsp_cnt_ff;
   assign rsp_if.run_last   = rsp_last_ff;
   assign rsp_if.used_count = rsp_used_ff;
   assign rsp_if.free_count = rsp_free_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // Both indices stay inside the ring in use.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, wr_idx_ff} < size_ff) && ({1'b0, rd_idx_ff} < size_ff))
      else $error("ring index beyond ring size");

   // One slot always stays empty.
   assert property (@(posedge clock) disable iff (reset)
      used_now < size_ff)
      else $error("ring overfilled");

   // Fetched read data exists only during a read run.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (st_ff == ST_READ))
      else $error("read data pending outside a read run");

   // The last byte of a run returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      (move && pend_last_ff) |=> (st_ff == ST_IDLE) && !pend_ff)
      else $error("read run did not end on its last byte");

endmodule

`default_nettype wire

// ===== verif/byte_ring_buffer_unit_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// byte_ring_buffer_unit_test
// Self-checking bench for the byte ring buffer: a queue-fed request driver,
// a result monitor and a mirror of the ring predict and check
// every result, across several ring sizes and idle patterns.
// ============================================================================

module byte_ring_buffer_unit_test;
   import brb_pkg::*;

   // Run length guard and the quiet time allowed before a size write and at
   // the end. The longest single request is a 63-byte read.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASE_ITEMS   = 24;
   localparam int NUM_PHASES    = 9;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [LEN_W-1:0]  req_length;
      logic [BYTE_W-1:0] push_byte;
   } ring_request_type;

   typedef struct packed {
      logic              ok;
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic [LEN_W-1:0]  byte_count;
      logic              run_last;
      logic [LEN_W-1:0]  used_count;
      logic [LEN_W-1:0]  free_count;
   } ring_result_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   brb_req_if req_ch ();
   brb_rsp_if rsp_ch ();

   byte_ring_buffer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Requests waiting to be driven, and results the mirror says must come.
   ring_request_type pending_requests [$];
   ring_result_type  pending_results [$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int queued_items = 0;
   // Largest push that fits an empty ring at the current size; only used to
   // steer the random lengths toward requests that succeed.
   int fit_cap = 63;
   // Request handshake seen at the last rising edge, read by the driver.
   bit req_fire = 1'b0;

   // -------------------------------------------------------------------------
   // Mirror of the ring: its own copy of the memory, indices, push progress
   // and size.
   // -------------------------------------------------------------------------
   logic [BYTE_W-1:0] ring_mirror [DEPTH];
   int  ring_slots   = DEPTH;
   int  wr_ptr       = 0;
   int  rd_ptr       = 0;
   int  push_seen    = 0;
   bit  push_fits    = 1'b0;

   function automatic int stored_bytes();
      if (wr_ptr >= rd_ptr) begin
         return wr_ptr - rd_ptr;
      end
      return ring_slots - (rd_ptr - wr_ptr);
   endfunction

   function automatic void post_result(bit ok, int data, bit valid, int count,
                                       bit last, int used);
      ring_result_type res;
      res.ok         = ok;
      res.out_byte   = BYTE_W'(data);
      res.byte_valid = valid;
      res.byte_count = LEN_W'(count);
      res.run_last   = last;
      res.used_count = LEN_W'(used);
      res.free_count = LEN_W'(ring_slots - 1 - used);
      pending_results.push_back(res);
   endfunction

   // A size write clamps into 2..DEPTH and empties the ring, dropping any
   // push that was under way.
   function automatic void load_ring_size(logic [SIZE_W-1:0] value);
      int v;
      v = value;
      if (v < SIZE_MIN) begin
         v = SIZE_MIN;
      end
      if (v > SIZE_MAX) begin
         v = SIZE_MAX;
      end
      ring_slots = v;
      wr_ptr     = 0;
      rd_ptr     = 0;
      push_seen  = 0;
      push_fits  = 1'b0;
   endfunction

   function automatic void predict_ring_response(ring_request_type r);
      int used;
      int room;
      int n;
      int after;
      used = stored_bytes();
      room = ring_slots - 1 - used;

      if (r.req_type == REQ_PUSH) begin
         // Room is decided on the first byte of a run; a run whose length
         // grows past the free space turns into a failing push.
         if (push_seen == 0) begin
            if (r.req_length == 0) begin
               post_result(1'b0, 0, 1'b0, 0, 1'b1, used);
               return;
            end
            push_fits = (r.req_length <= room);
         end
         if (push_fits && push_seen >= room) begin
            push_fits = 1'b0;
         end
         if (push_fits) begin
            ring_mirror[(wr_ptr + push_seen) % ring_slots] = r.push_byte;
         end
         push_seen++;
         if (push_seen >= r.req_length) begin
            if (push_fits) begin
               wr_ptr = (wr_ptr + push_seen) % ring_slots;
            end
            post_result(push_fits, 0, 1'b0, push_fits ? push_seen : 0, 1'b1,
                        stored_bytes());
            push_seen = 0;
            push_fits = 1'b0;
         end
         return;
      end

      // Any other request silently abandons an unfinished push.
      push_seen = 0;
      push_fits = 1'b0;

      if (r.req_type == REQ_DISCARD) begin
         if (r.req_length == 0 || r.req_length > used) begin
            post_result(1'b0, 0, 1'b0, 0, 1'b1, used);
            return;
         end
         rd_ptr = (rd_ptr + r.req_length) % ring_slots;
         post_result(1'b1, 0, 1'b0, r.req_length, 1'b1, stored_bytes());
         return;
      end

      // Peek and pop return min(length, used) bytes; pop also consumes them.
      if (r.req_length == 0 || used == 0) begin
         post_result(1'b0, 0, 1'b0, 0, 1'b1, used);
         return;
      end
      n     = (r.req_length < used) ? r.req_length : used;
      after = (r.req_type == REQ_POP) ? used - n : used;
      for (int k = 0; k < n; k++) begin
         post_result(1'b1, ring_mirror[(rd_ptr + k) % ring_slots], 1'b1, n,
                     k + 1 == n, after);
      end
      if (r.req_type == REQ_POP) begin
         rd_ptr = (rd_ptr + n) % ring_slots;
      end
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Clock, and the watchdog that bounds the run.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driver: inputs change on the falling edge. A request stays on the bus
   // until the edge that accepts it; after that the next one may follow at
   // once, or the sender idles first.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.req_type   <= REQ_PUSH;
         req_ch.req_length <= '0;
         req_ch.push_byte  <= '0;
      end else if (!req_ch.valid || req_fire) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.req_type   <= pending_requests[0].req_type;
            req_ch.req_length <= pending_requests[0].req_length;
            req_ch.push_byte  <= pending_requests[0].push_byte;
            req_ch.valid      <= 1'b1;
            void'(pending_requests.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // -------------------------------------------------------------------------
   // Monitor: everything is sampled on the rising edge. Size writes and
   // accepted requests update the mirror first, so every result that is
   // checked finds its expectation already queued.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      ring_request_type seen_req;
      ring_result_type  want;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (reset) begin
         load_ring_size(SIZE_MAX);
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            load_ring_size(csr_wr_data);
         end
         if (req_fire) begin
            seen_req.req_type   = req_ch.req_type;
            seen_req.req_length = req_ch.req_length;
            seen_req.push_byte  = req_ch.push_byte;
            predict_ring_response(seen_req);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("result arrived with no request outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("ok", want.ok, rsp_ch.ok);
               check_field("out_byte", want.out_byte, rsp_ch.out_byte);
               check_field("byte_valid", want.byte_valid, rsp_ch.byte_valid);
               check_field("byte_count", want.byte_count, rsp_ch.byte_count);
               check_field("run_last", want.run_last, rsp_ch.run_last);
               check_field("used_count", want.used_count, rsp_ch.used_count);
               check_field("free_count", want.free_count, rsp_ch.free_count);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   task automatic queue_request(logic [TYPE_W-1:0] kind, int length, int data);
      ring_request_type r;
      r.req_type   = kind;
      r.req_length = LEN_W'(length);
      r.push_byte  = BYTE_W'(data);
      pending_requests.push_back(r);
      queued_items++;
   endtask

   // Every queued request accepted and every predicted result delivered.
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_ch.valid || pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The size register is only written with the ring idle; the extra wait
   // covers a push left unfinished, which produces no result to wait on.
   task automatic write_ring_size(int value);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= SIZE_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      fit_cap = (value < SIZE_MIN) ? SIZE_MIN - 1 :
                (value > SIZE_MAX) ? SIZE_MAX - 1 : value - 1;
   endtask

   // One random request sequence. Most are well-formed push runs and reads
   // sized to the ring; the rest are oversized or broken runs and
   // zero-length requests.
   task automatic add_random_sequence();
      int pick;
      int len;
      int cut;
      int top;
      logic [TYPE_W-1:0] kind;
      pick = $urandom_range(99);
      if (pick < 45) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, fit_cap);
         for (int k = 0; k < len; k++) begin
            queue_request(REQ_PUSH, len, $urandom_range(255));
         end
      end else if (pick < 55) begin
         // A run cut short, sometimes with its length changed along the way.
         top = (fit_cap + 2 > 63) ? 63 : fit_cap + 2;
         len = $urandom_range(2, top);
         cut = $urandom_range(1, len - 1);
         for (int k = 0; k < cut; k++) begin
            queue_request(REQ_PUSH, ($urandom_range(3) == 0) ? $urandom_range(1, 63) : len,
                          $urandom_range(255));
         end
      end else if (pick < 62) begin
         case ($urandom_range(3))
            0: kind = REQ_PUSH;
            1: kind = REQ_PEEK;
            2: kind = REQ_DISCARD;
            default: kind = REQ_POP;
         endcase
         queue_request(kind, 0, $urandom_range(255));
      end else begin
         case ($urandom_range(2))
            0: kind = REQ_PEEK;
            1: kind = REQ_DISCARD;
            default: kind = REQ_POP;
         endcase
         len = ($urandom_range(4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, fit_cap);
         queue_request(kind, len, $urandom_range(255));
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   int  size_plan [NUM_PHASES] = '{127, 1, 7, 64, 65, 20, -1, 3, -1};
   bit  held_once = 1'b0;

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset size of 64 slots. Sender idles lightly,
      // receiver heavily.
      send_idle_pct = 19;
      recv_idle_pct = 67;
      queue_request(REQ_POP, 0, 8'h00);       // zero length
      queue_request(REQ_PEEK, 5, 8'h00);      // nothing to read
      queue_request(REQ_POP, 1, 8'hFF);       // nothing to read
      queue_request(REQ_DISCARD, 1, 8'h00);   // discard from an empty ring
      queue_request(REQ_PUSH, 0, 8'h11);      // zero-length push
      queue_request(REQ_PUSH, 3, 8'h00);
      queue_request(REQ_PUSH, 3, 8'hFF);
      queue_request(REQ_PUSH, 3, 8'hA5);
      queue_request(REQ_PEEK, 63, 8'h00);     // peek longer than what is stored
      queue_request(REQ_DISCARD, 4, 8'h00);   // more than stored: fails
      queue_request(REQ_DISCARD, 1, 8'h00);
      queue_request(REQ_POP, 2, 8'h00);
      // A push interrupted by a peek is dropped, so the peek sees nothing.
      queue_request(REQ_PUSH, 4, 8'h12);
      queue_request(REQ_PUSH, 4, 8'h34);
      queue_request(REQ_PEEK, 1, 8'h00);
      // The length shrinks mid-run and the run ends when the count meets it.
      queue_request(REQ_PUSH, 5, 8'h5A);
      queue_request(REQ_PUSH, 2, 8'hC3);
      queue_request(REQ_POP, 63, 8'h00);

      // Smallest ring, reached by a size below range: one usable byte.
      write_ring_size(0);
      queue_request(REQ_PUSH, 2, 8'h77);      // too large, consumed to its end
      queue_request(REQ_PUSH, 2, 8'h88);
      queue_request(REQ_PUSH, 1, 8'h3C);
      queue_request(REQ_PUSH, 1, 8'hE1);      // ring full
      queue_request(REQ_POP, 63, 8'h00);

      // Three slots: a run that fits at first but grows past the free space.
      write_ring_size(3);
      queue_request(REQ_PUSH, 2, 8'h01);
      queue_request(REQ_PUSH, 3, 8'h02);
      queue_request(REQ_PUSH, 3, 8'h03);

      // Random part: a new ring size per phase, extremes included, with the
      // idle pattern moving from a slow receiver to a slow sender to none.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_ring_size((size_plan[p] < 0) ? $urandom_range(0, 127) : size_plan[p]);
         if (p < 3) begin
            send_idle_pct = 19;
            recv_idle_pct = 67;
         end else if (p < 6) begin
            send_idle_pct = 67;
            recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queued_items = 0;
         while (queued_items < PHASE_ITEMS) begin
            // Once, halfway through a phase, hold the sender until the ring
            // has answered everything sent so far.
            if (p == 4 && !held_once && queued_items >= PHASE_ITEMS / 2) begin
               wait_until_drained();
               held_once = 1'b1;
            end
            add_random_sequence();
         end
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/brb_pkg.sv
hdl/brb_req_if.sv
hdl/brb_rsp_if.sv
hdl/byte_ring_buffer_unit.sv
verif/byte_ring_buffer_unit_test.sv
